// File: rtl/dq_pkg.sv
// Shared types, sizes, operation and status codes for the double-ended queue.
// Depends on nothing; imported by dq_ctrl and the top level.
`default_nettype none
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [ST_W-1:0]          t_status;

    localparam t_cnt CNT_DEPTH = CNT_W'(DEPTH);
    localparam t_idx IDX_LAST  = IDX_W'(DEPTH - 1);

    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_REAR  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_REAR   = 3'd3;
    localparam t_op OP_LIST       = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_UNDERFLOW = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_word wdata;
        logic  re;
        t_idx  raddr;
    } t_ram_req;

    typedef struct packed {
        logic    valid;
        logic    from_ram;
        t_status status;
        logic    last;
    } t_issue;

    function automatic t_idx ring_add(input t_idx base, input t_cnt off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/dq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/dq_ctrl.sv
// Deque control: front index, entry count, list sequencer and RAM requests.
// Depends on dq_pkg; drives the entry RAM and the result stage of the top level.
`default_nettype none
module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_op      i_operation,
    input  wire t_word    i_value,
    output logic          o_busy,
    output t_ram_req      o_req,
    output t_issue        o_issue
);

    t_idx r_front, n_front;
    t_cnt r_count, n_count;
    t_cnt r_next,  n_next;
    logic r_listing, n_listing;

    logic accept;
    logic is_full;
    logic is_empty;

    assign o_busy   = r_listing;
    assign accept   = i_start && !r_listing;
    assign is_full  = (r_count == CNT_DEPTH);
    assign is_empty = (r_count == '0);

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_next    = r_next;
        n_listing = r_listing;
        o_req     = '0;
        o_issue   = '0;
        if (accept) begin
            case (i_operation)
                OP_PUSH_FRONT, OP_PUSH_REAR: begin
                    o_issue.valid = 1'b1;
                    o_issue.last  = 1'b1;
                    if (is_full) begin
                        o_issue.status = ST_OVERFLOW;
                    end else begin
                        o_issue.status = ST_OK;
                        o_req.we       = 1'b1;
                        o_req.wdata    = i_value;
                        n_count        = r_count + CNT_W'(1);
                        if (i_operation == OP_PUSH_FRONT) begin
                            n_front     = (r_front == '0) ? IDX_LAST : r_front - IDX_W'(1);
                            o_req.waddr = n_front;
                        end else begin
                            o_req.waddr = ring_add(r_front, r_count);
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_REAR: begin
                    o_issue.valid = 1'b1;
                    o_issue.last  = 1'b1;
                    if (is_empty) begin
                        o_issue.status = ST_UNDERFLOW;
                    end else begin
                        o_issue.status   = ST_OK;
                        o_issue.from_ram = 1'b1;
                        o_req.re         = 1'b1;
                        n_count          = r_count - CNT_W'(1);
                        if (i_operation == OP_POP_FRONT) begin
                            o_req.raddr = r_front;
                            n_front     = ring_add(r_front, CNT_W'(1));
                        end else begin
                            o_req.raddr = ring_add(r_front, r_count - CNT_W'(1));
                        end
                    end
                end
                OP_LIST: begin
                    o_issue.valid = 1'b1;
                    if (is_empty) begin
                        o_issue.status = ST_EMPTY;
                        o_issue.last   = 1'b1;
                    end else begin
                        o_issue.status   = ST_OK;
                        o_issue.from_ram = 1'b1;
                        o_issue.last     = (r_count == CNT_W'(1));
                        o_req.re         = 1'b1;
                        o_req.raddr      = r_front;
                        n_listing        = (r_count != CNT_W'(1));
                        n_next           = CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end else if (r_listing) begin
            o_issue.valid    = 1'b1;
            o_issue.status   = ST_OK;
            o_issue.from_ram = 1'b1;
            o_issue.last     = (r_next == r_count - CNT_W'(1));
            o_req.re         = 1'b1;
            o_req.raddr      = ring_add(r_front, r_next);
            n_next           = r_next + CNT_W'(1);
            n_listing        = !o_issue.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_next    <= '0;
            r_listing <= 1'b0;
        end else begin
            r_front   <= n_front;
            r_count   <= n_count;
            r_next    <= n_next;
            r_listing <= n_listing;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_DEPTH)
        else $error("entry count above depth");
    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_listing |-> (r_next != '0) && (r_next < r_count))
        else $error("list cursor out of range");
    a_list_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_listing |=> $stable(r_count) && $stable(r_front))
        else $error("deque state moved during list");
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req.we && o_req.re))
        else $error("read and write issued together");
`endif

endmodule
`default_nettype wire

// File: rtl/double_ended_queue_core.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on dq_pkg, dq_ctrl and dq_ram.
//
// An operation is taken on a clock edge where start is high and busy is low.
// Pushes and pops may be issued back to back; the single result appears in the
// cycle after the transfer, held for exactly one cycle with o_valid high, since
// the receiver cannot stall. A list operation reads one entry per cycle through
// the single RAM read port, so it holds busy high until its last entry is read;
// its results stream out one per cycle, front first, o_last on the final one.
// Unused operation codes are taken and produce no result.
`default_nettype none
module double_ended_queue_core
    import dq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_op  i_operation,
    input  wire t_word i_value,
    output logic      o_valid,
    output t_word     o_data,
    output t_status   o_status,
    output logic      o_last
);

    t_ram_req ram_req;
    t_issue   issue;
    t_word    ram_rdata;

    logic     r_valid;
    logic     r_from_ram;
    t_status  r_status;
    logic     r_last;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_busy      (busy),
        .o_req       (ram_req),
        .o_issue     (issue)
    );

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= issue.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from_ram <= issue.from_ram;
        r_status   <= issue.status;
        r_last     <= issue.last;
    end

    assign o_valid  = r_valid;
    assign o_data   = r_from_ram ? ram_rdata : '0;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule
`default_nettype wire
